[rtl/odometer_lcd_char_sequencer_macros.svh]
// Assertion macros shared by the odometer LCD character sequencer.
`ifndef ODOMETER_LCD_CHAR_SEQUENCER_MACROS_SVH
`define ODOMETER_LCD_CHAR_SEQUENCER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define OCS_ASSERT_IMPLY(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define OCS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[rtl/ocs_pkg.sv]
// Package: types, character codes and reciprocal tables of the LCD sequencer.
`timescale 1ns / 1ps

package ocs_pkg;

   // defaults for top-level parameters
   localparam int FRAME_END_DEFAULT   = 81;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int VALUE_W = 24;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 24'd9999999;

   // LCD codes
   localparam logic [7:0] CMD_HOME = 8'h80;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_UP_M  = 8'd77;
   localparam logic [7:0] CH_UP_K  = 8'd75;
   localparam logic [7:0] CH_LO_I  = 8'd105;
   localparam logic [7:0] CH_LO_M  = 8'd109;
   localparam logic [7:0] CH_UP_E  = 8'd69;
   localparam logic [7:0] CH_UP_R  = 8'd82;
   localparam logic [7:0] CH_UP_O  = 8'd79;

   // reciprocal multiply: floor(v / d) = (v * M) >> S, exact for v < 2**24
   localparam int RECIP_W   = 25;
   localparam int SHIFT_W   = 6;
   localparam int PRODUCT_W = VALUE_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 25'd26843546;
   localparam int SHIFT_TEN = 28;

   typedef enum logic [0:0] {
      KIND_LITERAL,
      KIND_DIGIT
   } kind_type;

   // word passed from the front to the back through the middle queue
   typedef struct packed {
      logic               is_command;
      kind_type           kind;
      logic [7:0]         lit_byte;
      logic [2:0]         pow_idx;   // digit place: 0 tenths .. 6 hundred-thousands
      logic [VALUE_W-1:0] value;
   } mid_entry_type;

   // result word
   typedef struct packed {
      logic       is_command;
      logic [7:0] lcd_byte;
   } rsp_word_type;

   // multiplier for division by 10**idx
   function automatic logic [RECIP_W-1:0] recip_mult(input logic [2:0] idx);
      logic [RECIP_W-1:0] m;
      unique case (idx)
         3'd0:    m = 25'd1;
         3'd1:    m = 25'd26843546;
         3'd2:    m = 25'd21474837;
         3'd3:    m = 25'd17179870;
         3'd4:    m = 25'd27487791;
         3'd5:    m = 25'd21990233;
         3'd6:    m = 25'd17592187;
         default: m = 25'd1;
      endcase
      return m;
   endfunction

   // shift paired with recip_mult
   function automatic logic [SHIFT_W-1:0] recip_shift(input logic [2:0] idx);
      logic [SHIFT_W-1:0] s;
      unique case (idx)
         3'd0:    s = 6'd0;
         3'd1:    s = 6'd28;
         3'd2:    s = 6'd31;
         3'd3:    s = 6'd34;
         3'd4:    s = 6'd38;
         3'd5:    s = 6'd41;
         3'd6:    s = 6'd44;
         default: s = 6'd0;
      endcase
      return s;
   endfunction

   // letters of ERROR
   function automatic logic [7:0] err_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = CH_UP_E;
         3'd1:    c = CH_UP_R;
         3'd2:    c = CH_UP_R;
         3'd3:    c = CH_UP_O;
         3'd4:    c = CH_UP_R;
         default: c = CH_SPACE;
      endcase
      return c;
   endfunction

endpackage

[rtl/ocs_queue.sv]
// Small register queue with registered head, used between the stages.
`timescale 1ns / 1ps

module ocs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/ocs_front.sv]
// Front: keeps the screen position and classifies each tick into a literal or a digit.
`timescale 1ns / 1ps

module ocs_front #(
   parameter int FRAME_END = ocs_pkg::FRAME_END_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [ocs_pkg::VALUE_W-1:0]  req_total_distance,
   input  logic [ocs_pkg::VALUE_W-1:0]  req_trip_distance,
   input  logic                         req_miles_select,
   input  logic                         req_error_mode,
   output logic                         mid_push,
   output ocs_pkg::mid_entry_type       mid_entry,
   input  logic                         mid_full
);
   import ocs_pkg::*;

   localparam logic [7:0] POS_END = 8'(FRAME_END);

   logic [7:0]         position_ff, position_in;
   logic               line_two;
   logic [7:0]         offset;
   logic [VALUE_W-1:0] raw_value;
   logic [VALUE_W-1:0] clamped_value;

   assign req_full = mid_full;
   assign mid_push = req_push && !mid_full;

   // pick the line and clamp its value
   assign line_two      = (position_ff >= 8'd41) && (position_ff <= 8'd53);
   assign offset        = line_two ? (position_ff - 8'd40) : position_ff;
   assign raw_value     = line_two ? req_trip_distance : req_total_distance;
   assign clamped_value = (raw_value > VALUE_MAX) ? VALUE_MAX : raw_value;

   // classify the current position
   always_comb begin
      mid_entry            = '0;
      mid_entry.is_command = 1'b0;
      mid_entry.kind       = KIND_LITERAL;
      mid_entry.lit_byte   = CH_SPACE;
      mid_entry.pow_idx    = 3'd0;
      mid_entry.value      = clamped_value;
      position_in          = position_ff + 8'd1;
      priority if (position_ff == POS_END) begin
         mid_entry.is_command = 1'b1;
         mid_entry.lit_byte   = CMD_HOME;
         position_in          = 8'd1;
      end else if (req_error_mode) begin
         if ((position_ff >= 8'd6) && (position_ff <= 8'd10)) begin
            mid_entry.lit_byte = err_char(3'(position_ff - 8'd6));
         end
      end else if (line_two || ((position_ff >= 8'd1) && (position_ff <= 8'd13))) begin
         priority if ((offset >= 8'd4) && (offset <= 8'd9)) begin
            mid_entry.kind    = KIND_DIGIT;
            mid_entry.pow_idx = 3'(8'd10 - offset);
         end else if (offset == 8'd10) begin
            mid_entry.lit_byte = CH_DOT;
         end else if (offset == 8'd11) begin
            mid_entry.kind    = KIND_DIGIT;
            mid_entry.pow_idx = 3'd0;
         end else if (offset == 8'd12) begin
            mid_entry.lit_byte = req_miles_select ? CH_UP_M : CH_UP_K;
         end else if (offset == 8'd13) begin
            mid_entry.lit_byte = req_miles_select ? CH_LO_I : CH_LO_M;
         end else begin
            // leading blanks of a distance line
            mid_entry.lit_byte = CH_SPACE;
         end
      end else begin
         // blank filler outside both lines
         mid_entry.lit_byte = CH_SPACE;
      end
   end

   // advance the position on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 8'd1;
      end else if (mid_push) begin
         position_ff <= position_in;
      end
   end

endmodule

[rtl/ocs_back.sv]
// Back: extracts decimal digits through two reciprocal-multiply stages.
`timescale 1ns / 1ps

module ocs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ocs_pkg::mid_entry_type  mid_head,
   input  logic                    mid_empty,
   output logic                    mid_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output ocs_pkg::rsp_word_type   out_word
);
   import ocs_pkg::*;

   logic                 advance;

   // stage A: quotient by the digit place
   logic                 a_valid_ff;
   logic                 a_cmd_ff;
   kind_type             a_kind_ff;
   logic [7:0]           a_byte_ff;
   logic [VALUE_W-1:0]   a_quot_ff, a_quot_in;
   logic [PRODUCT_W-1:0] a_product;

   // stage B: low bits of quotient and of quotient / 10
   logic                 b_valid_ff;
   logic                 b_cmd_ff;
   kind_type             b_kind_ff;
   logic [7:0]           b_byte_ff;
   logic [3:0]           b_quot_lo_ff;
   logic [3:0]           b_q10_lo_ff, b_q10_lo_in;
   logic [PRODUCT_W-1:0] b_product;

   logic [3:0]           digit;

   // hold the whole pipe while the last stage cannot drain
   assign advance  = !(b_valid_ff && out_full);
   assign mid_pop  = advance && !mid_empty;
   assign out_push = b_valid_ff && !out_full;

   // divide by 10**place
   assign a_product = PRODUCT_W'(mid_head.value) * PRODUCT_W'(recip_mult(mid_head.pow_idx));
   assign a_quot_in = VALUE_W'(a_product >> recip_shift(mid_head.pow_idx));

   // divide the quotient by ten
   assign b_product   = PRODUCT_W'(a_quot_ff) * PRODUCT_W'(RECIP_TEN);
   assign b_q10_lo_in = b_product[SHIFT_TEN +: 4];

   // remainder by ten needs only the low four bits
   assign digit = b_quot_lo_ff - ((b_q10_lo_ff << 3) + (b_q10_lo_ff << 1));

   always_comb begin
      out_word.is_command = b_cmd_ff;
      unique case (b_kind_ff)
         KIND_DIGIT:   out_word.lcd_byte = CH_ZERO + {4'd0, digit};
         KIND_LITERAL: out_word.lcd_byte = b_byte_ff;
         default:      out_word.lcd_byte = b_byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= !mid_empty;
         b_valid_ff <= a_valid_ff;
      end
   end

   // move payload down the pipe
   always_ff @(posedge clock) begin
      if (advance) begin
         a_cmd_ff     <= mid_head.is_command;
         a_kind_ff    <= mid_head.kind;
         a_byte_ff    <= mid_head.lit_byte;
         a_quot_ff    <= a_quot_in;
         b_cmd_ff     <= a_cmd_ff;
         b_kind_ff    <= a_kind_ff;
         b_byte_ff    <= a_byte_ff;
         b_quot_lo_ff <= a_quot_ff[3:0];
         b_q10_lo_ff  <= b_q10_lo_in;
      end
   end

endmodule

[rtl/odometer_lcd_char_sequencer.sv]
// Top level of the odometer LCD character sequencer.
//
//   channel  | direction | handshake      | fields
//   ---------+-----------+----------------+------------------------------------------
//   req      | in        | push / full    | total_distance, trip_distance,
//            |           |                | miles_select, error_mode
//   rsp      | out       | empty / pop    | is_command, lcd_byte
//
// One word is taken per cycle and one result word leaves per cycle while no full queue stalls the flow.
// A word that is taken passes through the middle queue, then the two multiply stages
// of the digit unit, then the result queue.
// Synchronous reset puts the screen position at 1 and empties both queues.
// A full result queue stalls the digit unit; the middle queue then fills and
// raises req_full, so each side stalls without losing a word.
`timescale 1ns / 1ps
`include "odometer_lcd_char_sequencer_macros.svh"

module odometer_lcd_char_sequencer #(
   parameter int FRAME_END   = ocs_pkg::FRAME_END_DEFAULT,
   parameter int QUEUE_DEPTH = ocs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [ocs_pkg::VALUE_W-1:0] req_total_distance,
   input  logic [ocs_pkg::VALUE_W-1:0] req_trip_distance,
   input  logic                        req_miles_select,
   input  logic                        req_error_mode,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic                        rsp_is_command,
   output logic [7:0]                  rsp_lcd_byte
);
   import ocs_pkg::*;

   localparam int MID_W = $bits(mid_entry_type);
   localparam int RSP_W = $bits(rsp_word_type);

   logic          mid_push, mid_full, mid_pop, mid_empty;
   mid_entry_type mid_entry, mid_head;
   logic          out_push, out_full;
   rsp_word_type  out_word, out_head;

   ocs_front #(
      .FRAME_END (FRAME_END)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_total_distance (req_total_distance),
      .req_trip_distance  (req_trip_distance),
      .req_miles_select   (req_miles_select),
      .req_error_mode     (req_error_mode),
      .mid_push           (mid_push),
      .mid_entry          (mid_entry),
      .mid_full           (mid_full)
   );

   // decouple classification from digit extraction
   ocs_queue #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_entry),
      .full      (mid_full),
      .pop       (mid_pop),
      .head_data (mid_head),
      .empty     (mid_empty)
   );

   ocs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_head  (mid_head),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_word)
   );

   // hold finished words for the consumer
   ocs_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_word),
      .full      (out_full),
      .pop       (rsp_pop),
      .head_data (out_head),
      .empty     (rsp_empty)
   );

   assign rsp_is_command = out_head.is_command;
   assign rsp_lcd_byte   = out_head.lcd_byte;

   // the only command is cursor home
   `OCS_ASSERT_IMPLY(a_cmd_home, clock, reset, !rsp_empty && rsp_is_command, rsp_lcd_byte == CMD_HOME, "command word is not cursor home")

   // data characters stay in the printable set used on screen
   `OCS_ASSERT_IMPLY(a_data_range, clock, reset, !rsp_empty && !rsp_is_command, (rsp_lcd_byte >= CH_SPACE) && (rsp_lcd_byte <= CH_LO_M), "data character out of range")

   // a word written to the result queue is visible next cycle
   `OCS_ASSERT_NEXT(a_push_shows, clock, reset, out_push, !rsp_empty, "pushed result word not visible")

   // the digit unit never pushes into a full result queue
   `OCS_ASSERT_IMPLY(a_stall_hold, clock, reset, out_full, !out_push, "result word pushed while result queue full")

endmodule
